/* rtl/vector_tile_geometry_decoder_defines.svh */
// Assertion macros used by the geometry decoder port checker.
`ifndef VECTOR_TILE_GEOMETRY_DECODER_DEFINES_SVH
`define VECTOR_TILE_GEOMETRY_DECODER_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define VTGD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define VTGD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/vtgd_pkg.sv */
// Shared types, constants and functions of the geometry decoder.
package vtgd_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned CMD_ID_W = 3;
   localparam int unsigned COUNT_W = WORD_W - CMD_ID_W;

   // Command ids that arm coordinate pairs.
   localparam logic [CMD_ID_W-1:0] CMD_MOVE_TO = 3'd1;
   localparam logic [CMD_ID_W-1:0] CMD_LINE_TO = 3'd2;

   // One input word as held in the input register.
   typedef struct packed {
      logic [WORD_W-1:0] geo_word;
      logic              last_word;
   } word_type;

   // Handshake between input register and decode stage.
   typedef struct packed {
      logic     valid;
      word_type data;
   } stage_type;

   // Zigzag decode: 0,1,2,3 -> 0,-1,1,-2.
   function automatic logic [WORD_W-1:0] zz_decode(input logic [WORD_W-1:0] n);
      zz_decode = {1'b0, n[WORD_W-1:1]} ^ {WORD_W{n[0]}};
   endfunction

endpackage

/* rtl/vector_tile_geometry_decoder.sv */
// Vector tile geometry decoder: one geometry word in per cycle while results
// are taken, points out. Each accepted word is held in the input register,
// then decoded; a y word loads its point into the result register, and
// decoding waits while that register holds a result not yet taken. A word
// with no point (command, x word) moves through the same stage without
// producing a result. req_ready drops only while a word is held and the
// pending result is not being taken. State returns to its reset value after
// any word marked as last.
module vector_tile_geometry_decoder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [vtgd_pkg::WORD_W-1:0]       req_geo_word,
   input  logic                              req_last_word,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [vtgd_pkg::WORD_W-1:0] rsp_point_x,
   output logic signed [vtgd_pkg::WORD_W-1:0] rsp_point_y,
   output logic                              rsp_geometry_end
);
   import vtgd_pkg::*;

   stage_type stage;
   logic      stage_take;

   vtgd_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_geo_word  (req_geo_word),
      .req_last_word (req_last_word),
      .stage_out     (stage),
      .stage_take    (stage_take)
   );

   vtgd_decode u_decode (
      .clock            (clock),
      .reset            (reset),
      .stage_in         (stage),
      .stage_take       (stage_take),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_point_x      (rsp_point_x),
      .rsp_point_y      (rsp_point_y),
      .rsp_geometry_end (rsp_geometry_end)
   );

endmodule

/* rtl/vtgd_in_stage.sv */
// Input register of the geometry decoder.
module vtgd_in_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [vtgd_pkg::WORD_W-1:0] req_geo_word,
   input  logic                      req_last_word,
   output vtgd_pkg::stage_type       stage_out,
   input  logic                      stage_take
);
   import vtgd_pkg::*;

   logic     valid_ff, valid_in;
   word_type data_ff;

   // Take a new word when empty or when the held word moves on this cycle.
   assign req_ready = !valid_ff || stage_take;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load payload on accept.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff.geo_word  <= req_geo_word;
         data_ff.last_word <= req_last_word;
      end
   end

   assign stage_out.valid = valid_ff;
   assign stage_out.data  = data_ff;

endmodule

/* rtl/vtgd_decode.sv */
// Command decode, cursor update and result register of the geometry decoder.
module vtgd_decode (
   input  logic                              clock,
   input  logic                              reset,
   input  vtgd_pkg::stage_type               stage_in,
   output logic                              stage_take,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [vtgd_pkg::WORD_W-1:0] rsp_point_x,
   output logic signed [vtgd_pkg::WORD_W-1:0] rsp_point_y,
   output logic                              rsp_geometry_end
);
   import vtgd_pkg::*;

   logic [WORD_W-1:0]   cursor_x_ff, cursor_x_in;
   logic [WORD_W-1:0]   cursor_y_ff, cursor_y_in;
   logic [COUNT_W-1:0]  pairs_left_ff, pairs_left_in;
   logic                awaiting_y_ff, awaiting_y_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]   point_x_ff, point_y_ff;
   logic                geometry_end_ff;

   logic                fire;
   logic                is_cmd;
   logic                emit;
   logic [CMD_ID_W-1:0] cmd_id;
   logic [COUNT_W-1:0]  cmd_count;
   logic [WORD_W-1:0]   delta;

   // Move a word on whenever the result register is free or drains now.
   assign stage_take = !rsp_valid_ff || rsp_ready;
   assign fire       = stage_in.valid && stage_take;

   assign is_cmd    = (pairs_left_ff == '0) && !awaiting_y_ff;
   assign cmd_id    = stage_in.data.geo_word[CMD_ID_W-1:0];
   assign cmd_count = stage_in.data.geo_word[WORD_W-1:CMD_ID_W];
   assign delta     = zz_decode(stage_in.data.geo_word);
   assign emit      = !is_cmd && awaiting_y_ff;

   // Advance decode state.
   always_comb begin
      cursor_x_in   = cursor_x_ff;
      cursor_y_in   = cursor_y_ff;
      pairs_left_in = pairs_left_ff;
      awaiting_y_in = awaiting_y_ff;
      if (fire) begin
         if (is_cmd) begin
            if (cmd_id == CMD_MOVE_TO || cmd_id == CMD_LINE_TO) begin
               pairs_left_in = cmd_count;
            end
         end else if (!awaiting_y_ff) begin
            cursor_x_in   = cursor_x_ff + delta;
            awaiting_y_in = 1'b1;
         end else begin
            cursor_y_in   = cursor_y_ff + delta;
            awaiting_y_in = 1'b0;
            pairs_left_in = pairs_left_ff - 1'b1;
         end
         // Drop everything at the end of a geometry.
         if (stage_in.data.last_word) begin
            cursor_x_in   = '0;
            cursor_y_in   = '0;
            pairs_left_in = '0;
            awaiting_y_in = 1'b0;
         end
      end
   end

   // Result register valid: set on a point, clear when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff   <= '0;
         cursor_y_ff   <= '0;
         pairs_left_ff <= '0;
         awaiting_y_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cursor_x_ff   <= cursor_x_in;
         cursor_y_ff   <= cursor_y_in;
         pairs_left_ff <= pairs_left_in;
         awaiting_y_ff <= awaiting_y_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Load the point when its y word arrives.
   always_ff @(posedge clock) begin
      if (fire && emit) begin
         point_x_ff      <= cursor_x_ff;
         point_y_ff      <= cursor_y_ff + delta;
         geometry_end_ff <= stage_in.data.last_word;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_point_x      = $signed(point_x_ff);
   assign rsp_point_y      = $signed(point_y_ff);
   assign rsp_geometry_end = geometry_end_ff;

endmodule

/* rtl/vtgd_checker.sv */
// Port-level checker of the geometry decoder, bound to the top level.
`include "vector_tile_geometry_decoder_defines.svh"

module vtgd_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [vtgd_pkg::WORD_W-1:0]       req_geo_word,
   input logic                              req_last_word,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [vtgd_pkg::WORD_W-1:0] rsp_point_x,
   input logic signed [vtgd_pkg::WORD_W-1:0] rsp_point_y,
   input logic                              rsp_geometry_end
);
   import vtgd_pkg::*;

   logic unused_req;
   assign unused_req = req_valid ^ req_last_word ^ (^req_geo_word);

   // No result right out of reset.
   `VTGD_ASSERT_NOW(a_no_rsp_after_reset, clock, reset, $past(reset), !rsp_valid, "result after reset")

   // Stalled result word holds.
   `VTGD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_point_x) && $stable(rsp_point_y) && $stable(rsp_geometry_end), "stalled result changed")

   // Input stalls only under output back-pressure.
   `VTGD_ASSERT_NOW(a_ready_only_on_stall, clock, reset, !req_ready, rsp_valid && !rsp_ready, "input stalled without back-pressure")

endmodule

bind vector_tile_geometry_decoder vtgd_checker u_vtgd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_geo_word     (req_geo_word),
   .req_last_word    (req_last_word),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_point_x      (rsp_point_x),
   .rsp_point_y      (rsp_point_y),
   .rsp_geometry_end (rsp_geometry_end)
);

/* dv/vector_tile_geometry_decoder_checker.sv */
// Point predictor and result checker for the geometry decoder.
module vector_tile_geometry_decoder_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic [vtgd_pkg::WORD_W-1:0]        req_geo_word,
   input  logic                               req_last_word,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic signed [vtgd_pkg::WORD_W-1:0] rsp_point_x,
   input  logic signed [vtgd_pkg::WORD_W-1:0] rsp_point_y,
   input  logic                               rsp_geometry_end,
   output int                                 fail_count,
   output int                                 points_pending,
   output int                                 points_checked
);
   import vtgd_pkg::*;

   typedef struct packed {
      logic [WORD_W-1:0] x;
      logic [WORD_W-1:0] y;
      logic              geometry_end;
   } point_type;

   // Predicted decoder state.
   logic [WORD_W-1:0]  pen_x;
   logic [WORD_W-1:0]  pen_y;
   logic [COUNT_W-1:0] pairs_armed;
   logic               y_pending;
   point_type          points_due[$];

   // Odd codes are negative: 1 -> -1, 3 -> -2; even codes halve.
   function automatic logic [WORD_W-1:0] unzigzag(input logic [WORD_W-1:0] code);
      return code[0] ? ~(code >> 1) : (code >> 1);
   endfunction

   task automatic clear_pen();
      pen_x       = '0;
      pen_y       = '0;
      pairs_armed = '0;
      y_pending   = 1'b0;
   endtask

   // Advance the predicted state by one word; queue a point on each y word.
   task automatic decode_word(input logic [WORD_W-1:0] w, input logic last);
      point_type pt;
      if (pairs_armed == '0 && !y_pending) begin
         if (w[CMD_ID_W-1:0] == CMD_MOVE_TO || w[CMD_ID_W-1:0] == CMD_LINE_TO)
            pairs_armed = w[WORD_W-1:CMD_ID_W];
      end else if (!y_pending) begin
         pen_x     = pen_x + unzigzag(w);
         y_pending = 1'b1;
      end else begin
         pen_y           = pen_y + unzigzag(w);
         y_pending       = 1'b0;
         pairs_armed     = pairs_armed - 1'b1;
         pt.x            = pen_x;
         pt.y            = pen_y;
         pt.geometry_end = last;
         points_due.push_back(pt);
      end
      // drop all state after the final word of a geometry
      if (last)
         clear_pen();
   endtask

   // Compare each result word with the oldest predicted point, then predict.
   always @(posedge clock) begin : check_points
      point_type due;
      if (reset) begin
         clear_pen();
         points_due.delete();
         fail_count     = 0;
         points_checked = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (points_due.size() == 0) begin
               $error("rsp word with no point due: x %0d y %0d end %0b",
                      rsp_point_x, rsp_point_y, rsp_geometry_end);
               fail_count++;
            end else begin
               due = points_due.pop_front();
               points_checked++;
               if (rsp_point_x !== due.x) begin
                  $error("point_x: expected %0d, got %0d", $signed(due.x), rsp_point_x);
                  fail_count++;
               end
               if (rsp_point_y !== due.y) begin
                  $error("point_y: expected %0d, got %0d", $signed(due.y), rsp_point_y);
                  fail_count++;
               end
               if (rsp_geometry_end !== due.geometry_end) begin
                  $error("geometry_end: expected %0b, got %0b",
                         due.geometry_end, rsp_geometry_end);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            decode_word(req_geo_word, req_last_word);
      end
      points_pending = points_due.size();
   end

endmodule

/* dv/tb_vector_tile_geometry_decoder.sv */
// Testbench top for the geometry decoder: word stimulus, flow control and verdict.
module tb_vector_tile_geometry_decoder;
   import vtgd_pkg::*;

   localparam logic [CMD_ID_W-1:0] CMD_CLOSE_PATH = 3'd7;
   localparam int WORDS_PER_PHASE = 250;
   localparam int HOLD_OFF_CYCLES = 120;
   localparam int DRAIN_CYCLES    = 8;
   localparam int CYCLE_LIMIT     = 200000;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [WORD_W-1:0]        req_geo_word;
   logic                     req_last_word;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic signed [WORD_W-1:0] rsp_point_x;
   logic signed [WORD_W-1:0] rsp_point_y;
   logic                     rsp_geometry_end;

   int fail_count;
   int points_pending;
   int points_checked;
   int send_idle_pct   = 0;
   int recv_stall_pct  = 0;
   int hold_off_len    = 0;
   int hold_left       = 0;
   int words_sent      = 0;
   int geometries_sent = 0;
   int cycle_count     = 0;

   logic [WORD_W-1:0] geo_words[$];

   vector_tile_geometry_decoder i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_geo_word     (req_geo_word),
      .req_last_word    (req_last_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_point_x      (rsp_point_x),
      .rsp_point_y      (rsp_point_y),
      .rsp_geometry_end (rsp_geometry_end)
   );

   vector_tile_geometry_decoder_checker i_checker (.*);

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", CYCLE_LIMIT);
         $display("vector_tile_geometry_decoder: mismatch");
         $finish;
      end
   end

   // Drive rsp_ready: serve a requested hold-off first, else stall at random.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (hold_off_len > 0) begin
         rsp_ready <= 1'b0;
         hold_left    = hold_off_len - 1;
         hold_off_len = 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic logic [WORD_W-1:0] cmd_word(input logic [CMD_ID_W-1:0] id,
                                                  input logic [COUNT_W-1:0] count);
      return {count, id};
   endfunction

   // Mix short zigzag deltas, the extreme codes and full random words.
   function automatic logic [WORD_W-1:0] rand_delta();
      case ($urandom_range(3))
         0: return WORD_W'($urandom_range(63));
         1: return $urandom_range(1) ? {WORD_W{1'b1}} : {{(WORD_W-1){1'b1}}, 1'b0};
         default: return $urandom;
      endcase
   endfunction

   // Offer one word; idle first at random, then hold it until accepted.
   task automatic send_word(input logic [WORD_W-1:0] w, input logic last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct)
            @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_geo_word  <= w;
      req_last_word <= last;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      words_sent++;
   endtask

   // Send the built geometry, marking its final word.
   task automatic send_geometry();
      foreach (geo_words[i])
         send_word(geo_words[i], i == geo_words.size() - 1);
      geo_words.delete();
      geometries_sent++;
   endtask

   // Build one random geometry: mostly well formed, some cut short, some noise.
   task automatic build_geometry();
      int                  kind;
      int                  npairs;
      logic [CMD_ID_W-1:0] id;
      kind = $urandom_range(99);
      if (kind < 75) begin
         repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(9))
               0:       id = CMD_CLOSE_PATH;
               1:       id = CMD_ID_W'($urandom);
               2, 3, 4: id = CMD_MOVE_TO;
               default: id = CMD_LINE_TO;
            endcase
            npairs = $urandom_range(5);
            geo_words.push_back(cmd_word(id, COUNT_W'(npairs)));
            if (id == CMD_MOVE_TO || id == CMD_LINE_TO)
               repeat (2 * npairs) geo_words.push_back(rand_delta());
         end
      end else if (kind < 90) begin
         // arm any count, then end the geometry at an arbitrary word
         id = $urandom_range(1) ? CMD_MOVE_TO : CMD_LINE_TO;
         geo_words.push_back(cmd_word(id, COUNT_W'($urandom)));
         repeat ($urandom_range(7)) geo_words.push_back(rand_delta());
      end else begin
         repeat ($urandom_range(1, 6)) geo_words.push_back($urandom);
      end
      send_geometry();
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input int hold);
      int start;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      hold_off_len   = hold;
      start          = words_sent;
      while (words_sent - start < WORDS_PER_PHASE)
         build_geometry();
   endtask

   initial begin
      int cmd_id;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_geo_word  <= '0;
      req_last_word <= 1'b0;
      rsp_ready     <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // two commands share the cursor; extreme deltas wrap it, ends on a y word
      geo_words.push_back(cmd_word(CMD_MOVE_TO, COUNT_W'(1)));
      geo_words.push_back({{(WORD_W-1){1'b1}}, 1'b0});
      geo_words.push_back({WORD_W{1'b1}});
      geo_words.push_back(cmd_word(CMD_LINE_TO, COUNT_W'(2)));
      geo_words.push_back(32'd1);
      geo_words.push_back(32'd0);
      geo_words.push_back({{(WORD_W-1){1'b1}}, 1'b0});
      geo_words.push_back(32'd2);
      send_geometry();

      // zero count, close path and unknown ids, then a trailing unpaired x
      geo_words.push_back(cmd_word(CMD_MOVE_TO, COUNT_W'(0)));
      for (cmd_id = 0; cmd_id < (1 << CMD_ID_W); cmd_id++) begin
         if (cmd_id != CMD_MOVE_TO && cmd_id != CMD_LINE_TO)
            geo_words.push_back(cmd_word(CMD_ID_W'(cmd_id),
                                         cmd_id[0] ? {COUNT_W{1'b1}} : COUNT_W'($urandom)));
      end
      geo_words.push_back(cmd_word(CMD_LINE_TO, {COUNT_W{1'b1}}));
      geo_words.push_back(32'd5);
      geo_words.push_back(32'd6);
      geo_words.push_back(32'h1234_5679);
      send_geometry();

      // command as the final word
      geo_words.push_back(cmd_word(CMD_MOVE_TO, COUNT_W'(3)));
      send_geometry();

      // cursor starts over after the clear
      geo_words.push_back(cmd_word(CMD_MOVE_TO, COUNT_W'(1)));
      geo_words.push_back(32'd4);
      geo_words.push_back({WORD_W{1'b1}});
      send_geometry();

      // random geometries under each idling mix, then a long receiver hold-off
      run_phase(0, 0, 0);
      run_phase(68, 0, 0);
      run_phase(0, 68, 0);
      run_phase(16, 16, 0);
      run_phase(0, 0, HOLD_OFF_CYCLES);

      // drain outstanding points
      req_valid <= 1'b0;
      @(posedge clock);
      while (points_pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d words in %0d geometries, compared %0d points",
               words_sent, geometries_sent, points_checked);
      $display("flow control: free, sender gaps, receiver stalls, both, %0d-cycle hold-off",
               HOLD_OFF_CYCLES);
      if (fail_count == 0)
         $display("vector_tile_geometry_decoder: match");
      else
         $display("vector_tile_geometry_decoder: mismatch");
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/vtgd_pkg.sv
rtl/vtgd_in_stage.sv
rtl/vtgd_decode.sv
rtl/vector_tile_geometry_decoder.sv
rtl/vtgd_checker.sv
dv/vector_tile_geometry_decoder_checker.sv
dv/tb_vector_tile_geometry_decoder.sv
